@@ src/assert_macros.svh @@
// assertion macros used by the ring buffer top level
// needs clk and arst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while in reset
`define OLRB_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("olrb assertion failed");

// next-cycle implication, off while in reset
`define OLRB_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("olrb assertion failed");

`endif

@@ src/olrb_pkg.sv @@
// shared types, constants and helpers of the overwriting log ring buffer
// no dependencies
`timescale 1ns / 1ps

package olrb_pkg;

	// store geometry and read cap
	localparam int STORE_DEPTH = 4096;
	localparam int MAX_READ    = 64;
	localparam int AW          = $clog2(STORE_DEPTH);
	localparam int LW          = $clog2(STORE_DEPTH + 1);
	localparam int CNT_W       = 6;
	localparam int LIM_IN_W    = 7;

	// request codes and the line break byte
	localparam logic       REQ_APPEND   = 1'b0;
	localparam logic       REQ_READ     = 1'b1;
	localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

	// input word
	typedef struct packed {
		logic                req_type;
		logic [7:0]          data_byte;
		logic [LIM_IN_W-1:0] read_limit;
	} req_t;

	// result word
	typedef struct packed {
		logic [7:0]       out_byte;
		logic             out_last;
		logic [CNT_W-1:0] copied_count;
	} res_t;

	// controller to datapath commands
	typedef struct packed {
		logic append;
		logic rd_load;
		logic scan_en;
		logic copy_en;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic full;
		logic scan_hit;
		logic scan_end;
		logic copy_end;
	} stat_t;

	// ring position step with wrap
	function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
		return (p == AW'(STORE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

endpackage

@@ src/olrb_ram.sv @@
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module olrb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ src/olrb_ctrl.sv @@
// sequencer of the ring buffer: accepts requests and steps reads through scan and copy
// depends on olrb_pkg
`timescale 1ns / 1ps

module olrb_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  olrb_pkg::req_t req,
	input  olrb_pkg::stat_t stat,
	output olrb_pkg::cmd_t cmd,
	output logic           busy
);
	import olrb_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_COPY = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic   take;
	logic   rd_ok;

	// request decode
	assign take  = start && (state_q == ST_IDLE);
	assign rd_ok = (req.req_type == REQ_READ) && (req.read_limit != '0);

	// commands to the datapath
	always_comb begin
		cmd         = '0;
		cmd.append  = take && (req.req_type == REQ_APPEND);
		cmd.rd_load = take && rd_ok;
		cmd.scan_en = (state_q == ST_SCAN);
		cmd.copy_en = (state_q == ST_COPY);
	end

	assign busy = (state_q != ST_IDLE);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (take && rd_ok) begin
					state_d = stat.full ? ST_SCAN : ST_COPY;
				end
			end
			ST_SCAN: begin
				if (stat.scan_hit || stat.scan_end) begin
					state_d = ST_COPY;
				end
			end
			ST_COPY: begin
				if (stat.copy_end) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ src/olrb_dp.sv @@
// datapath of the ring buffer: positions, byte store, read walk and result register
// depends on olrb_pkg and olrb_ram
`timescale 1ns / 1ps

module olrb_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  olrb_pkg::req_t  req,
	input  olrb_pkg::cmd_t  cmd,
	output olrb_pkg::stat_t stat,
	output logic            res_stb,
	output olrb_pkg::res_t  res
);
	import olrb_pkg::*;

	logic [AW-1:0]    old_q, nw_q;
	logic             full_q;
	logic [AW-1:0]    ptr_q;
	logic [LW-1:0]    len_q;
	logic [LW-1:0]    off_q;
	logic [CNT_W-1:0] lim_q;
	logic [CNT_W-1:0] copied_q;
	logic             rd_v_s1;
	logic [AW-1:0]    addr_s1;
	logic [AW-1:0]    off_s1;
	logic             res_stb_q;
	res_t             res_q;

	logic [7:0]          rdata;
	logic [AW-1:0]       old_nx;
	logic [AW-1:0]       nw_nx;
	logic [LW-1:0]       len_init;
	logic [LIM_IN_W-1:0] lim_cap;
	logic                hit;
	logic                scan_last;
	logic                scan_iss;
	logic                cp_iss;
	logic                copy_end;

	// append position update
	assign old_nx = full_q ? ring_next(old_q) : old_q;
	assign nw_nx  = ring_next(nw_q);

	// stored length and capped limit at read start
	always_comb begin
		if (full_q) begin
			len_init = LW'(STORE_DEPTH);
		end else if (nw_q >= old_q) begin
			len_init = LW'(nw_q) - LW'(old_q);
		end else begin
			len_init = LW'(STORE_DEPTH) - LW'(old_q) + LW'(nw_q);
		end
		lim_cap = (req.read_limit > LIM_IN_W'(MAX_READ)) ? LIM_IN_W'(MAX_READ)
			: req.read_limit;
	end

	// newline scan and copy issue
	assign hit       = cmd.scan_en && rd_v_s1 && (rdata == NEWLINE_BYTE);
	assign scan_last = cmd.scan_en && rd_v_s1 && !hit && (off_s1 == AW'(STORE_DEPTH - 1));
	assign scan_iss  = cmd.scan_en && !hit && !scan_last && (off_q < LW'(STORE_DEPTH));
	assign cp_iss    = cmd.copy_en && (len_q != '0) && (lim_q != '0);
	assign copy_end  = cmd.copy_en && !cp_iss && !rd_v_s1;

	always_comb begin
		stat          = '0;
		stat.full     = full_q;
		stat.scan_hit = hit;
		stat.scan_end = scan_last;
		stat.copy_end = copy_end;
	end

	olrb_ram #(
		.WIDTH(8),
		.DEPTH(STORE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (cmd.append),
		.waddr(nw_q),
		.wdata(req.data_byte),
		.re   (scan_iss || cp_iss),
		.raddr(ptr_q),
		.rdata(rdata)
	);

	// ring positions and walk counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			old_q     <= '0;
			nw_q      <= '0;
			full_q    <= 1'b0;
			ptr_q     <= '0;
			len_q     <= '0;
			off_q     <= '0;
			lim_q     <= '0;
			copied_q  <= '0;
			rd_v_s1   <= 1'b0;
			res_stb_q <= 1'b0;
		end else begin
			rd_v_s1   <= scan_iss || cp_iss;
			res_stb_q <= (cmd.copy_en && rd_v_s1) || copy_end;
			if (cmd.append) begin
				old_q  <= old_nx;
				nw_q   <= nw_nx;
				full_q <= (nw_nx == old_nx);
			end
			if (cmd.rd_load) begin
				ptr_q    <= old_q;
				len_q    <= len_init;
				off_q    <= '0;
				lim_q    <= CNT_W'(lim_cap - 1'b1);
				copied_q <= '0;
			end
			if (scan_iss) begin
				ptr_q <= ring_next(ptr_q);
				off_q <= off_q + 1'b1;
			end
			if (hit) begin
				ptr_q <= ring_next(addr_s1);
				len_q <= LW'(STORE_DEPTH - 1) - LW'(off_s1);
			end
			if (scan_last) begin
				ptr_q <= old_q;
			end
			if (cp_iss) begin
				ptr_q <= ring_next(ptr_q);
				len_q <= len_q - 1'b1;
				lim_q <= lim_q - 1'b1;
			end
			if (cmd.copy_en && rd_v_s1) begin
				copied_q <= copied_q + 1'b1;
			end
		end
	end

	// scan tags follow the read data
	always_ff @(posedge clk) begin
		if (scan_iss) begin
			addr_s1 <= ptr_q;
			off_s1  <= off_q[AW-1:0];
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.copy_en && rd_v_s1) begin
			res_q.out_byte     <= rdata;
			res_q.out_last     <= 1'b0;
			res_q.copied_count <= '0;
		end else if (copy_end) begin
			res_q.out_byte     <= '0;
			res_q.out_last     <= 1'b1;
			res_q.copied_count <= copied_q;
		end
	end

	assign res_stb = res_stb_q;
	assign res     = res_q;

endmodule

@@ src/overwriting_log_ring_buffer.sv @@
// Overwriting log ring buffer, top level.
// Command channel: a word is taken at a clock edge where start is high and busy is low.
// req.req_type selects append (one byte into the ring) or read (copy out stored text).
// An append never raises busy, so while no read runs appends are taken every cycle;
// a full ring drops its oldest byte. A read with a zero limit is dropped without results.
// A read raises busy and walks the store through the one read port of the byte RAM,
// one byte per cycle. On a full ring it first scans for the first newline, then goes
// back to the byte after it, or to the oldest byte if the scan finds none.
// It then copies up to min(limit, 64) - 1 bytes and a zero terminator with out_last
// and copied_count. Result words show on res with res_stb for exactly one cycle;
// the receiver cannot stall them. Each copied byte passes the RAM read register and
// the result register, and the terminator is the word after the last byte. busy falls
// as the terminator is registered, so the next command can be taken while it is on
// the result port. A read never changes the store.
// Reset clears positions, full flag and sequencer; the byte RAM is not cleared,
// and no entry is read before it was written.
// depends on olrb_pkg, olrb_ctrl, olrb_dp, assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module overwriting_log_ring_buffer (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  olrb_pkg::req_t req,
	output logic           busy,
	output logic           res_stb,
	output olrb_pkg::res_t res
);
	import olrb_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// sequencer
	olrb_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.req   (req),
		.stat  (stat),
		.cmd   (cmd),
		.busy  (busy)
	);

	// store and walk datapath
	olrb_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.stat   (stat),
		.res_stb(res_stb),
		.res    (res)
	);

	// checks
	`OLRB_ASSERT_IMPL(a_res_in_read, res_stb, $past(busy))
	`OLRB_ASSERT_IMPL(a_count_on_last, res_stb && !res.out_last, res.copied_count == '0)
	`OLRB_ASSERT_NEXT(a_read_busy,
		start && !busy && (req.req_type == REQ_READ) && (req.read_limit != '0), busy)

endmodule

@@ bench/tb_overwriting_log_ring_buffer.sv @@
// self-checking bench for the overwriting log ring buffer: directed table, then random phases
// predicts results by ring model or fixed terminator; depends on olrb_pkg and the rtl top
`timescale 1ns / 1ps

module tb_overwriting_log_ring_buffer;
	import olrb_pkg::*;

	localparam int CYCLE_LIMIT = 6000000;
	localparam int TAIL_CYCLES = 24;

	// how a directed row is checked
	typedef enum logic [1:0] {
		CHK_MODEL,
		CHK_NONE,
		CHK_TERM0
	} chk_e;

	typedef struct {
		req_t w;
		chk_e chk;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	req_t req;
	logic busy;
	logic res_stb;
	res_t res;

	// ring model state
	logic [7:0] ring_mem [STORE_DEPTH];
	int         head_pos;
	int         tail_pos;
	bit         ring_full;

	res_t       pending_res [$];
	dir_row_t   dir_rows [$];
	int         mismatches;
	int         cycle_count;
	int         calm_left;

	overwriting_log_ring_buffer u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (busy),
		.res_stb(res_stb),
		.res    (res)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// append one byte, oldest dropped when full
	function automatic void ring_append(input logic [7:0] b);
		if (ring_full)
			head_pos = (head_pos + 1) % STORE_DEPTH;
		ring_mem[tail_pos] = b;
		tail_pos  = (tail_pos + 1) % STORE_DEPTH;
		ring_full = (tail_pos == head_pos);
	endfunction

	// expected words of one read: text after the first line break when full, then terminator
	function automatic void ring_read(input int limit);
		int   lim;
		int   len;
		int   first;
		int   cnt;
		bit   found;
		res_t word;
		lim = limit;
		if (lim == 0)
			return;
		if (lim > MAX_READ)
			lim = MAX_READ;
		len   = ring_full ? STORE_DEPTH : (tail_pos - head_pos + STORE_DEPTH) % STORE_DEPTH;
		first = head_pos;
		found = 1'b0;
		if (ring_full) begin
			for (int off = 0; off < len && !found; off++) begin
				if (ring_mem[(head_pos + off) % STORE_DEPTH] == NEWLINE_BYTE) begin
					found = 1'b1;
					first = (head_pos + off + 1) % STORE_DEPTH;
					len   = len - off - 1;
				end
			end
		end
		cnt = 0;
		while (cnt < lim - 1 && cnt < len) begin
			word.out_byte     = ring_mem[(first + cnt) % STORE_DEPTH];
			word.out_last     = 1'b0;
			word.copied_count = '0;
			pending_res.push_back(word);
			cnt++;
		end
		word.out_byte     = 8'h00;
		word.out_last     = 1'b1;
		word.copied_count = CNT_W'(cnt);
		pending_res.push_back(word);
	endfunction

	// request builders, the unused field is random
	function automatic req_t mk_append(input logic [7:0] b);
		req_t w;
		w.req_type   = REQ_APPEND;
		w.data_byte  = b;
		w.read_limit = LIM_IN_W'($urandom_range(127));
		return w;
	endfunction

	function automatic req_t mk_read(input logic [LIM_IN_W-1:0] lim);
		req_t w;
		w.req_type   = REQ_READ;
		w.data_byte  = 8'($urandom_range(255));
		w.read_limit = lim;
		return w;
	endfunction

	// limit mix: mostly legal, some zero, some above the cap
	function automatic logic [LIM_IN_W-1:0] rand_limit();
		int r;
		r = $urandom_range(99);
		if (r < 8)
			return '0;
		if (r < 20)
			return LIM_IN_W'($urandom_range(127, MAX_READ + 1));
		return LIM_IN_W'($urandom_range(MAX_READ, 1));
	endfunction

	// text byte with a line break at the given percentage
	function automatic logic [7:0] rand_text(input int nl_pct);
		logic [7:0] b;
		if ($urandom_range(99) < nl_pct)
			return NEWLINE_BYTE;
		do
			b = 8'($urandom_range(255));
		while (b == NEWLINE_BYTE);
		return b;
	endfunction

	// sender gap: mostly none or short, a few long, with calm stretches
	function automatic int pick_gap();
		int r;
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		r = $urandom_range(99);
		if (r < 3)
			calm_left = $urandom_range(30, 10);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(3, 1);
		return $urandom_range(30, 5);
	endfunction

	// drive one word after a gap, wait until it is taken and busy is low, then predict
	task automatic issue(input req_t w, input chk_e chk);
		int gap;
		gap = pick_gap();
		repeat (gap) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start <= 1'b1;
		req   <= w;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (w.req_type == REQ_APPEND)
			ring_append(w.data_byte);
		else if (chk == CHK_MODEL)
			ring_read(int'(w.read_limit));
		else if (chk == CHK_TERM0)
			pending_res.push_back(res_t'{out_byte: 8'h00, out_last: 1'b1, copied_count: '0});
	endtask

	// hold the sender off until every expected word has come
	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (pending_res.size() != 0)
			@(negedge clk);
	endtask

	// directed rows, starting from an empty store
	task automatic build_table();
		dir_rows.push_back('{mk_read(7'd1), CHK_TERM0});
		dir_rows.push_back('{mk_read(7'd64), CHK_TERM0});
		dir_rows.push_back('{mk_read(7'd0), CHK_NONE});
		dir_rows.push_back('{mk_read(7'd127), CHK_TERM0});
		dir_rows.push_back('{mk_append(8'h00), CHK_NONE});
		dir_rows.push_back('{mk_append(8'hFF), CHK_NONE});
		dir_rows.push_back('{mk_append(NEWLINE_BYTE), CHK_NONE});
		dir_rows.push_back('{mk_append(8'h41), CHK_NONE});
		dir_rows.push_back('{mk_read(7'd0), CHK_NONE});
		dir_rows.push_back('{mk_read(7'd1), CHK_TERM0});
		dir_rows.push_back('{mk_read(7'd2), CHK_MODEL});
		dir_rows.push_back('{mk_read(7'd64), CHK_MODEL});
		dir_rows.push_back('{mk_read(7'd127), CHK_MODEL});
		dir_rows.push_back('{mk_read(7'd65), CHK_MODEL});
		dir_rows.push_back('{mk_append(8'h55), CHK_NONE});
		dir_rows.push_back('{mk_append(8'hAA), CHK_NONE});
		dir_rows.push_back('{mk_append(8'h7F), CHK_NONE});
		dir_rows.push_back('{mk_append(8'h80), CHK_NONE});
		dir_rows.push_back('{mk_read(7'd3), CHK_MODEL});
		dir_rows.push_back('{mk_read(7'd5), CHK_MODEL});
		dir_rows.push_back('{mk_read(7'd63), CHK_MODEL});
	endtask

	// result checker, oldest expectation first
	always @(posedge clk) begin : check_results
		res_t want;
		if (arst_n === 1'b1 && res_stb === 1'b1) begin
			if (pending_res.size() == 0) begin
				$display("%0t: unexpected word, expected none, actual %p", $time, res);
				mismatches++;
			end else begin
				want = pending_res.pop_front();
				if (res.out_byte !== want.out_byte) begin
					$display("%0t: out_byte expected %h actual %h",
						$time, want.out_byte, res.out_byte);
					mismatches++;
				end
				if (res.out_last !== want.out_last) begin
					$display("%0t: out_last expected %b actual %b",
						$time, want.out_last, res.out_last);
					mismatches++;
				end
				if (res.copied_count !== want.copied_count) begin
					$display("%0t: copied_count expected %0d actual %0d",
						$time, want.copied_count, res.copied_count);
					mismatches++;
				end
			end
		end
	end

	initial begin
		arst_n      = 1'b0;
		start       = 1'b0;
		req         = '0;
		head_pos    = 0;
		tail_pos    = 0;
		ring_full   = 1'b0;
		mismatches  = 0;
		cycle_count = 0;
		calm_left   = 0;
		build_table();

		// reset, released at a falling edge
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed table
		foreach (dir_rows[i])
			issue(dir_rows[i].w, dir_rows[i].chk);
		drain();

		// random mix while the store is still filling
		for (int i = 0; i < 200; i++) begin
			if ($urandom_range(99) < 75)
				issue(mk_append(rand_text(12)), CHK_MODEL);
			else
				issue(mk_read(rand_limit()), CHK_MODEL);
		end
		drain();

		// fill to full with text that has frequent line breaks
		while (!ring_full)
			issue(mk_append(rand_text(6)), CHK_MODEL);

		// random mix on a full store, oldest bytes get dropped
		for (int i = 0; i < 250; i++) begin
			if ($urandom_range(99) < 55)
				issue(mk_append(rand_text(10)), CHK_MODEL);
			else
				issue(mk_read(rand_limit()), CHK_MODEL);
		end
		drain();

		// full store with no line break at all
		for (int i = 0; i < STORE_DEPTH; i++)
			issue(mk_append(rand_text(0)), CHK_MODEL);
		issue(mk_read(7'd64), CHK_MODEL);
		issue(mk_read(rand_limit()), CHK_MODEL);
		issue(mk_read(7'd0), CHK_MODEL);

		// only line break is the newest byte, then one byte after it
		issue(mk_append(NEWLINE_BYTE), CHK_MODEL);
		issue(mk_read(7'd64), CHK_MODEL);
		issue(mk_append(8'h41), CHK_MODEL);
		issue(mk_read(7'd127), CHK_MODEL);

		// wind down
		@(negedge clk);
		start <= 1'b0;
		while (pending_res.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
